@@ hw/rtl/hptc_pkg.sv @@
package hptc_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned MUL_LAT = 2;
  localparam int unsigned DIV_LAT = DIV_STEPS + 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic signed [WORD_W-1:0] sword_t;

  localparam logic [2:0] CFG_TEMP_TRIM  = 3'd0;
  localparam logic [2:0] CFG_PRESS_LOW  = 3'd1;
  localparam logic [2:0] CFG_PRESS_HIGH = 3'd2;
  localparam logic [2:0] CFG_PRESS_LAST = 3'd3;
  localparam logic [2:0] CFG_HUM_TRIM   = 3'd4;

endpackage

@@ hw/rtl/hptc_mul.sv @@
module hptc_mul (
  input  logic          clk,
  input  logic          en,
  input  hptc_pkg::word_t a,
  input  hptc_pkg::word_t b,
  output hptc_pkg::word_t p
);

  // low 64 bits of the product, two stages of 32 by 32 partial products
  logic [63:0] lo_r;
  logic [31:0] xa_r;
  logic [31:0] xb_r;
  hptc_pkg::word_t p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r <= 64'(a[31:0]) * 64'(b[31:0]);
      xa_r <= a[31:0] * b[63:32];
      xb_r <= a[63:32] * b[31:0];
      p_r  <= lo_r + {xa_r + xb_r, 32'b0};
    end
  end

  assign p = p_r;

endmodule

@@ hw/rtl/hptc_dly.sv @@
module hptc_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[N-1];

endmodule

@@ hw/rtl/hptc_div.sv @@
module hptc_div (
  input  logic            clk,
  input  logic            en,
  input  hptc_pkg::word_t num,
  input  hptc_pkg::word_t den,
  output hptc_pkg::word_t quo
);

  localparam int unsigned N = hptc_pkg::DIV_STEPS;

  // restoring division on magnitudes, one quotient bit per stage
  hptc_pkg::word_t rem_r [N];
  hptc_pkg::word_t dv_r [N];
  hptc_pkg::word_t acc_r [N+1];
  logic            neg_r [N+1];
  hptc_pkg::word_t quo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      acc_r[0] <= num[63] ? -num : num;
      dv_r[0]  <= den[63] ? -den : den;
      neg_r[0] <= num[63] ^ den[63];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [64:0] sh;
    logic [64:0] df;
    assign sh = {rem_r[i], acc_r[i][63]};
    assign df = sh - {1'b0, dv_r[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[i+1] <= {acc_r[i][62:0], ~df[64]};
        neg_r[i+1] <= neg_r[i];
      end
    end

    if (i < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i+1] <= df[64] ? sh[63:0] : df[63:0];
          dv_r[i+1]  <= dv_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= neg_r[N] ? -acc_r[N] : acc_r[N];
    end
  end

  assign quo = quo_r;

endmodule

@@ hw/rtl/humidity_pressure_temp_compensation.sv @@
// Environmental sensor compensation: one raw measurement in, one result out.
// Input channel in_valid/in_ready carries raw pressure, temperature and
// humidity; output channel out_valid/out_ready carries temperature in
// 0.01 degC, humidity in Q7.10 %RH, pressure in Q17.8 Pa and a flag that
// is low when the pressure divisor came out zero. Calibration words are
// written on cfg_we/cfg_index/cfg_data by the user only while the block is
// idle; the block does not enforce it. Indices above four are ignored.
// A new item can be taken in every cycle while out_ready does not hold the
// pipeline; the datapath is built from the 64-stage pipelined divider and
// the chain of two-stage 64-bit multipliers feeding it.
// All stages move on one enable: when a result waits and out_ready is low
// the whole pipeline holds and in_ready drops, nothing is lost or repeated.
// Reset clears the calibration registers and all valid bits.
module humidity_pressure_temp_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        in_raw_pressure,
  input  logic [19:0]        in_raw_temperature,
  input  logic [15:0]        in_raw_humidity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] out_temperature_centi,
  output logic [16:0]        out_humidity_q10,
  output logic [24:0]        out_pressure_q8,
  output logic               out_pressure_valid,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int unsigned LAT = 88;
  localparam hptc_pkg::sword_t HUM_T_OFS = 64'sd76800;
  localparam hptc_pkg::sword_t PRS_T_OFS = 64'sd128000;

  logic [47:0] temp_trim_r;
  logic [63:0] press_lo_r;
  logic [63:0] press_hi_r;
  logic [15:0] press_last_r;
  logic [63:0] hum_trim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_trim_r  <= '0;
      press_lo_r   <= '0;
      press_hi_r   <= '0;
      press_last_r <= '0;
      hum_trim_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hptc_pkg::CFG_TEMP_TRIM:  temp_trim_r  <= cfg_data[47:0];
        hptc_pkg::CFG_PRESS_LOW:  press_lo_r   <= cfg_data;
        hptc_pkg::CFG_PRESS_HIGH: press_hi_r   <= cfg_data;
        hptc_pkg::CFG_PRESS_LAST: press_last_r <= cfg_data[15:0];
        hptc_pkg::CFG_HUM_TRIM:   hum_trim_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  hptc_pkg::sword_t t1c, t2c, t3c;
  hptc_pkg::sword_t p1c, p2c, p3c, p4c, p5c, p6c, p7c, p8c, p9c;
  hptc_pkg::sword_t h1c, h2c, h3c, h4c, h5c, h6c;

  assign t1c = {48'b0, temp_trim_r[15:0]};
  assign t2c = {{48{temp_trim_r[31]}}, temp_trim_r[31:16]};
  assign t3c = {{48{temp_trim_r[47]}}, temp_trim_r[47:32]};
  assign p1c = {48'b0, press_lo_r[15:0]};
  assign p2c = {{48{press_lo_r[31]}}, press_lo_r[31:16]};
  assign p3c = {{48{press_lo_r[47]}}, press_lo_r[47:32]};
  assign p4c = {{48{press_lo_r[63]}}, press_lo_r[63:48]};
  assign p5c = {{48{press_hi_r[15]}}, press_hi_r[15:0]};
  assign p6c = {{48{press_hi_r[31]}}, press_hi_r[31:16]};
  assign p7c = {{48{press_hi_r[47]}}, press_hi_r[47:32]};
  assign p8c = {{48{press_hi_r[63]}}, press_hi_r[63:48]};
  assign p9c = {{48{press_last_r[15]}}, press_last_r};
  assign h1c = {56'b0, hum_trim_r[7:0]};
  assign h2c = {{48{hum_trim_r[23]}}, hum_trim_r[23:8]};
  assign h3c = {56'b0, hum_trim_r[31:24]};
  assign h4c = {{52{hum_trim_r[43]}}, hum_trim_r[43:32]};
  assign h5c = {{52{hum_trim_r[55]}}, hum_trim_r[55:44]};
  assign h6c = {{56{hum_trim_r[63]}}, hum_trim_r[63:56]};

  logic en;
  logic out_valid_r;
  logic [LAT-1:0] vld_r;

  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LAT-2:0], in_valid};
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // input stage
  logic [19:0] adc_p_r, adc_t_r;
  logic [15:0] adc_h_r;

  always_ff @(posedge clk) begin
    if (en) begin
      adc_p_r <= in_raw_pressure;
      adc_t_r <= in_raw_temperature;
      adc_h_r <= in_raw_humidity;
    end
  end

  // temperature
  hptc_pkg::sword_t ta_r, td_r, m_t2, m_tdd, m_t3, ta_d, tfine_r, tt;
  logic signed [14:0] temp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ta_r <= {47'b0, adc_t_r[19:3]} - (t1c <<< 1);
      td_r <= {48'b0, adc_t_r[19:4]} - t1c;
    end
  end

  hptc_mul u_m_t2  (.clk, .en, .a(ta_r), .b(t2c), .p(m_t2));
  hptc_mul u_m_tdd (.clk, .en, .a(td_r), .b(td_r), .p(m_tdd));
  hptc_mul u_m_t3  (.clk, .en, .a(m_tdd >>> 12), .b(t3c), .p(m_t3));
  hptc_dly #(.W(64), .N(2)) u_d_ta (.clk, .en, .d(m_t2), .q(ta_d));

  assign tt = ((tfine_r <<< 2) + tfine_r + 64'sd128) >>> 8;

  always_ff @(posedge clk) begin
    if (en) begin
      tfine_r <= (ta_d >>> 11) + (m_t3 >>> 14);
      if (tt < -64'sd4000) begin
        temp_r <= -15'sd4000;
      end else if (tt > 64'sd8500) begin
        temp_r <= 15'sd8500;
      end else begin
        temp_r <= tt[14:0];
      end
    end
  end

  // humidity
  logic [15:0] adc_h6;
  hptc_pkg::sword_t hk_r, hk9, hx_r, m_h5, m_h6, m_h3, ha_r, hb_r, hc_r;
  hptc_pkg::sword_t m_bc, hc2_r, m_h2, hc3_r, ha16, m_ac, hxx23, hd_r;
  hptc_pkg::sword_t m_dd, m_h1, hdiff_r;
  logic [16:0] hum_r;

  hptc_dly #(.W(16), .N(6)) u_d_adch (.clk, .en, .d(adc_h_r), .q(adc_h6));

  always_ff @(posedge clk) begin
    if (en) begin
      hk_r <= ({48'b0, adc_h6} <<< 14) - (h4c <<< 20);
      hx_r <= tfine_r - HUM_T_OFS;
    end
  end

  hptc_dly #(.W(64), .N(2)) u_d_hk (.clk, .en, .d(hk_r), .q(hk9));
  hptc_mul u_m_h5 (.clk, .en, .a(hx_r), .b(h5c), .p(m_h5));
  hptc_mul u_m_h6 (.clk, .en, .a(hx_r), .b(h6c), .p(m_h6));
  hptc_mul u_m_h3 (.clk, .en, .a(hx_r), .b(h3c), .p(m_h3));

  always_ff @(posedge clk) begin
    if (en) begin
      ha_r  <= (hk9 - m_h5 + 64'sd16384) >>> 15;
      hb_r  <= m_h6 >>> 10;
      hc_r  <= (m_h3 >>> 11) + 64'sd32768;
      hc2_r <= (m_bc >>> 10) + 64'sd2097152;
      hc3_r <= (m_h2 + 64'sd8192) >>> 14;
      hd_r  <= m_ac >>> 15;
      hdiff_r <= hxx23 - (m_h1 >>> 4);
      if (hdiff_r < 64'sd0) begin
        hum_r <= '0;
      end else if (hdiff_r > 64'sd419430400) begin
        hum_r <= 17'd102400;
      end else begin
        hum_r <= hdiff_r[28:12];
      end
    end
  end

  hptc_mul u_m_bc (.clk, .en, .a(hb_r), .b(hc_r), .p(m_bc));
  hptc_mul u_m_h2 (.clk, .en, .a(hc2_r), .b(h2c), .p(m_h2));
  hptc_dly #(.W(64), .N(6)) u_d_ha (.clk, .en, .d(ha_r), .q(ha16));
  hptc_mul u_m_ac (.clk, .en, .a(ha16), .b(hc3_r), .p(m_ac));
  hptc_dly #(.W(64), .N(5)) u_d_hxx (.clk, .en, .d(m_ac), .q(hxx23));
  hptc_mul u_m_dd (.clk, .en, .a(hd_r), .b(hd_r), .p(m_dd));
  hptc_mul u_m_h1 (.clk, .en, .a(m_dd >>> 7), .b(h1c), .p(m_h1));

  // pressure
  logic [19:0] adcp12;
  hptc_pkg::sword_t pa_r, m_aa, m_a5, m_a2, m_p6, m_p3, a5_11, a2_11;
  hptc_pkg::sword_t pb_r, pq_r, m_p1, den_r, pn, nm_r, m_num, quo;
  hptc_pkg::sword_t pd83, q83, q85, m_9d, m_8p, m_9dd, b85, ps_r, pf_r;
  logic dz87;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= tfine_r - PRS_T_OFS;
      pb_r  <= m_p6 + (a5_11 <<< 17) + (p4c <<< 35);
      pq_r  <= (m_p3 >>> 8) + (a2_11 <<< 12) + 64'sh0000_8000_0000_0000;
      den_r <= m_p1 >>> 33;
      nm_r  <= (pn <<< 31) - pb_r;
    end
  end

  assign pn = 64'sd1048576 - {44'b0, adcp12};

  hptc_mul u_m_aa (.clk, .en, .a(pa_r), .b(pa_r), .p(m_aa));
  hptc_mul u_m_a5 (.clk, .en, .a(pa_r), .b(p5c), .p(m_a5));
  hptc_mul u_m_a2 (.clk, .en, .a(pa_r), .b(p2c), .p(m_a2));
  hptc_mul u_m_p6 (.clk, .en, .a(m_aa), .b(p6c), .p(m_p6));
  hptc_mul u_m_p3 (.clk, .en, .a(m_aa), .b(p3c), .p(m_p3));
  hptc_dly #(.W(64), .N(2)) u_d_a5 (.clk, .en, .d(m_a5), .q(a5_11));
  hptc_dly #(.W(64), .N(2)) u_d_a2 (.clk, .en, .d(m_a2), .q(a2_11));
  hptc_mul u_m_p1 (.clk, .en, .a(pq_r), .b(p1c), .p(m_p1));
  hptc_dly #(.W(20), .N(12)) u_d_adcp (.clk, .en, .d(adc_p_r), .q(adcp12));
  hptc_mul u_m_num (.clk, .en, .a(nm_r), .b(64'sd3125), .p(m_num));

  hptc_div u_div (.clk, .en, .num(m_num), .den(den_r), .quo(quo));
  hptc_dly #(.W(1), .N(72)) u_d_dz (.clk, .en, .d(den_r == 64'sd0), .q(dz87));

  hptc_mul u_m_9d (.clk, .en, .a(p9c), .b(quo >>> 13), .p(m_9d));
  hptc_mul u_m_8p (.clk, .en, .a(p8c), .b(quo), .p(m_8p));
  hptc_dly #(.W(64), .N(2)) u_d_pd (.clk, .en, .d(quo >>> 13), .q(pd83));
  hptc_dly #(.W(64), .N(2)) u_d_q83 (.clk, .en, .d(quo), .q(q83));
  hptc_dly #(.W(64), .N(2)) u_d_q85 (.clk, .en, .d(q83), .q(q85));
  hptc_mul u_m_9dd (.clk, .en, .a(m_9d), .b(pd83), .p(m_9dd));
  hptc_dly #(.W(64), .N(2)) u_d_b85 (.clk, .en, .d(m_8p >>> 19), .q(b85));

  always_ff @(posedge clk) begin
    if (en) begin
      ps_r <= q85 + (m_9dd >>> 25) + b85;
      pf_r <= (ps_r >>> 8) + (p7c <<< 4);
    end
  end

  // output register
  logic signed [14:0] temp87;
  logic [16:0] hum87;
  logic signed [14:0] out_temp_r;
  logic [16:0] out_hum_r;
  logic [24:0] out_press_r;
  logic out_pvalid_r;

  hptc_dly #(.W(15), .N(80)) u_d_temp (.clk, .en, .d(temp_r), .q(temp87));
  hptc_dly #(.W(17), .N(62)) u_d_hum (.clk, .en, .d(hum_r), .q(hum87));

  always_ff @(posedge clk) begin
    if (en) begin
      out_temp_r   <= temp87;
      out_hum_r    <= hum87;
      out_pvalid_r <= ~dz87;
      if (dz87 || pf_r < 64'sd0) begin
        out_press_r <= '0;
      end else if (pf_r > 64'sd33554431) begin
        out_press_r <= 25'h1FF_FFFF;
      end else begin
        out_press_r <= pf_r[24:0];
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = out_temp_r;
  assign out_humidity_q10      = out_hum_r;
  assign out_pressure_q8       = out_press_r;
  assign out_pressure_valid    = out_pvalid_r;

  a_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_pressure_valid) |-> (out_pressure_q8 == 25'd0))
    else $error("pressure not zero on divisor fault");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_centi >= -15'sd4000 &&
                   out_temperature_centi <= 15'sd8500))
    else $error("temperature out of range");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_humidity_q10 <= 17'd102400))
    else $error("humidity out of range");

endmodule
